// ===== rtl/nsc_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helpers for the sentence classifier.
// -----------------------------------------------------------------------------
package nsc_pkg;

   localparam int BYTE_W   = 8;
   localparam int ID_BYTES = 5;
   localparam int ID_W     = ID_BYTES * BYTE_W;

   localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
   localparam logic [BYTE_W-1:0] CHAR_BANG   = 8'h21;
   localparam logic [BYTE_W-1:0] CHAR_STAR   = 8'h2A;
   localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
   localparam logic [BYTE_W-1:0] PRINT_LO    = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI    = 8'h7E;

   localparam logic [BYTE_W-1:0] LEN_MAX     = 8'd255;
   localparam logic [BYTE_W-1:0] MIN_LEN     = 8'd6;
   localparam logic [BYTE_W-1:0] CS_TAIL     = 8'd6;
   localparam logic [BYTE_W:0]   CS_SPAN     = 9'd3;

   // register indexes
   localparam logic CSR_PORT_DIRECTION = 1'b0;
   localparam logic CSR_SENTENCE_LIMIT = 1'b1;

   localparam logic [1:0] DIR_OUTPUT_ONLY   = 2'd1;
   localparam logic [1:0] DIR_RESET         = 2'd2;
   localparam logic [BYTE_W-1:0] LIMIT_RESET = 8'd128;

   localparam logic [1:0] VERDICT_OK           = 2'd0;
   localparam logic [1:0] VERDICT_CANNOT_PARSE = 2'd1;
   localparam logic [1:0] VERDICT_BAD_CHECKSUM = 2'd2;

   typedef struct packed {
      logic              fire;
      logic              last;
      logic [BYTE_W-1:0] data;
   } beat_type;

   typedef struct packed {
      logic              active;
      logic [BYTE_W-1:0] length;
      logic [BYTE_W-1:0] run_xor;
      logic              unprintable;
      logic              star_seen;
      logic [BYTE_W-1:0] first_star;
      logic [BYTE_W-1:0] last_star;
      logic [BYTE_W-1:0] sent_cs;
      logic [1:0]        hex_ok;
      logic [ID_W-1:0]   id_bytes;
   } trk_state_type;

   // hex value in the low nibble, top bit set when not a hex digit
   function automatic logic [4:0] hex_value(input logic [BYTE_W-1:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, c[3:0]};
      end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
         v = {1'b0, c[3:0] + 4'd9};
      end else begin
         v = 5'h10;
      end
      return v;
   endfunction

endpackage

// ===== rtl/nmea_sentence_classifier.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nmea_sentence_classifier
// Byte-wide NMEA 0183 sentence checker with checksum and message id output.
// -----------------------------------------------------------------------------
// Takes one frame byte per clock. Each byte is registered, then updates two
// sentence trackers (one opened by '$', one by '!');
// on the frame's last byte the sentence is classified and, if a result is due,
// it is captured from the input register into the output register.
// The input is held off only when a frame-end beat finds the previous result
// still waiting to be taken. Configuration is written through the csr_ port
// by the user only while no frame is in flight; the block does not enforce it.
// -----------------------------------------------------------------------------
module nmea_sentence_classifier
   import nsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic              csr_index,
   input  logic [BYTE_W-1:0] csr_wdata,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [BYTE_W-1:0] req_frame_byte,
   input  logic              req_frame_end,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_verdict,
   output logic [ID_W-1:0]   rsp_message_id,
   output logic              rsp_had_checksum,
   output logic [BYTE_W-1:0] rsp_sentence_length
);

   logic [1:0]        port_direction_ff;
   logic [BYTE_W-1:0] sentence_limit_ff;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              in_end_ff;
   logic              accept;
   logic              fire;
   beat_type          beat;
   trk_state_type     trk_dollar;
   trk_state_type     trk_bang;

   always_ff @(posedge clock) begin
      if (reset) begin
         port_direction_ff <= DIR_RESET;
         sentence_limit_ff <= LIMIT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PORT_DIRECTION: port_direction_ff <= csr_wdata[1:0];
            CSR_SENTENCE_LIMIT: sentence_limit_ff <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // a frame-end beat needs the output register free
   assign fire      = in_valid_ff && (!in_end_ff || !rsp_valid || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;
   assign in_valid_in = accept ? 1'b1 : (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_frame_byte;
         in_end_ff  <= req_frame_end;
      end
   end

   assign beat.fire = fire;
   assign beat.last = in_end_ff;
   assign beat.data = in_byte_ff;

   nsc_tracker u_trk_dollar (
      .clock      (clock),
      .reset      (reset),
      .start_char (CHAR_DOLLAR),
      .beat       (beat),
      .trk_upd    (trk_dollar)
   );

   nsc_tracker u_trk_bang (
      .clock      (clock),
      .reset      (reset),
      .start_char (CHAR_BANG),
      .beat       (beat),
      .trk_upd    (trk_bang)
   );

   nsc_classify u_classify (
      .clock               (clock),
      .reset               (reset),
      .beat                (beat),
      .trk_dollar          (trk_dollar),
      .trk_bang            (trk_bang),
      .port_direction      (port_direction_ff),
      .sentence_limit      (sentence_limit_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_verdict),
      .rsp_message_id      (rsp_message_id),
      .rsp_had_checksum    (rsp_had_checksum),
      .rsp_sentence_length (rsp_sentence_length)
   );

endmodule

// ===== rtl/nsc_tracker.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nsc_tracker
// Follows one sentence from its start character: length, printable check,
// checksum xor, transmitted checksum digits, star positions and message id.
// -----------------------------------------------------------------------------
module nsc_tracker
   import nsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] start_char,
   input  beat_type          beat,
   output trk_state_type     trk_upd
);

   trk_state_type state_ff;
   trk_state_type state_in;

   logic [BYTE_W-1:0] p;
   logic [BYTE_W:0]   p_ext;
   logic [BYTE_W:0]   f_ext;
   logic [4:0]        h;
   logic [BYTE_W-1:0] b;

   assign b     = beat.data;
   assign p     = state_ff.length;
   assign p_ext = {1'b0, p};
   assign f_ext = {1'b0, state_ff.first_star};
   assign h     = hex_value(b);

   // state after this beat, before the end-of-frame clear
   always_comb begin
      trk_upd = state_ff;
      if (beat.fire) begin
         if (state_ff.active) begin
            if (p != LEN_MAX) begin
               trk_upd.length = p + 8'd1;
            end
            if (!((b >= PRINT_LO && b <= PRINT_HI) || b == CHAR_LF || b == CHAR_CR)) begin
               trk_upd.unprintable = 1'b1;
            end
            if (p >= 8'd1 && p <= 8'd5) begin
               trk_upd.id_bytes = {state_ff.id_bytes[ID_W-BYTE_W-1:0], b};
            end
            if (state_ff.star_seen) begin
               if (p_ext == f_ext + 9'd1) begin
                  trk_upd.sent_cs[7:4] = h[3:0];
                  trk_upd.hex_ok[0]    = ~h[4];
               end else if (p_ext == f_ext + 9'd2) begin
                  trk_upd.sent_cs[3:0] = h[3:0];
                  trk_upd.hex_ok[1]    = ~h[4];
               end
            end
            if (b == CHAR_STAR) begin
               if (!state_ff.star_seen) begin
                  trk_upd.star_seen  = 1'b1;
                  trk_upd.first_star = p;
               end
               trk_upd.last_star = p;
            end else if (!state_ff.star_seen && p != 8'd0) begin
               trk_upd.run_xor = state_ff.run_xor ^ b;
            end
         end else if (b == start_char) begin
            trk_upd.active = 1'b1;
            trk_upd.length = 8'd1;
         end
      end
   end

   always_comb begin
      state_in = trk_upd;
      if (beat.fire && beat.last) begin
         state_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/nsc_classify.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// nsc_classify
// Picks the sentence at frame end, classifies it and holds the result beat
// in the output register until it is taken.
// -----------------------------------------------------------------------------
module nsc_classify
   import nsc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  beat_type          beat,
   input  trk_state_type     trk_dollar,
   input  trk_state_type     trk_bang,
   input  logic [1:0]        port_direction,
   input  logic [BYTE_W-1:0] sentence_limit,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [1:0]        rsp_verdict,
   output logic [ID_W-1:0]   rsp_message_id,
   output logic              rsp_had_checksum,
   output logic [BYTE_W-1:0] rsp_sentence_length
);

   trk_state_type     sel;
   logic              emit;
   logic              garbage;
   logic              had_cs;
   logic              cs_ok;
   logic [1:0]        verdict;

   logic              valid_ff, valid_in;
   logic [1:0]        verdict_ff;
   logic [ID_W-1:0]   id_ff;
   logic              had_cs_ff;
   logic [BYTE_W-1:0] length_ff;

   always_comb begin
      sel = trk_dollar.active ? trk_dollar : trk_bang;
      emit = beat.fire && beat.last && (trk_dollar.active || trk_bang.active) &&
             port_direction != DIR_OUTPUT_ONLY && sel.length >= MIN_LEN;
      garbage = sel.length > sentence_limit || sel.length == LEN_MAX || sel.unprintable;
      had_cs  = sel.star_seen && sel.last_star >= sel.length - CS_TAIL;
      cs_ok   = sel.star_seen && ({1'b0, sel.length} >= {1'b0, sel.first_star} + CS_SPAN) &&
                sel.hex_ok == 2'b11 && sel.run_xor == sel.sent_cs;
      priority if (garbage) begin
         verdict = VERDICT_CANNOT_PARSE;
      end else if (had_cs && !cs_ok) begin
         verdict = VERDICT_BAD_CHECKSUM;
      end else begin
         verdict = VERDICT_OK;
      end
   end

   // the top only fires a frame end while the output register is free
   assign valid_in = emit ? 1'b1 : (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         verdict_ff <= verdict;
         id_ff      <= garbage ? '0 : sel.id_bytes;
         had_cs_ff  <= had_cs;
         length_ff  <= sel.length;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_verdict         = verdict_ff;
   assign rsp_message_id      = id_ff;
   assign rsp_had_checksum    = had_cs_ff;
   assign rsp_sentence_length = length_ff;

endmodule
